/* src/raster_median_filter_defines.svh */
// Assertion macros for the checking file of the raster median filter.
`ifndef RASTER_MEDIAN_FILTER_DEFINES_SVH
`define RASTER_MEDIAN_FILTER_DEFINES_SVH

// General form: a labelled concurrent assertion on a given clock and active-low reset.
`define RMF_ASSERT_ON(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("raster median filter check failed");

// Short form on the block's own clock and reset.
`define RMF_CHECK(label, prop) `RMF_ASSERT_ON(label, i_clk, i_rst_n, prop)

`endif

/* src/rmf_pkg.sv */
package rmf_pkg;

    localparam int PIX_W      = 8;
    localparam int ROW_W      = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int MAX_HEIGHT = 4096;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIM_K       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd3;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_in;
        logic             pad_item;
    } t_in_item;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             frame_end;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GATHER,
        ST_DRAIN,
        ST_SUM,
        ST_DIV,
        ST_LOAD
    } t_state;

    typedef struct packed {
        logic accept;
        logic gather_start;
        logic gather_step;
        logic sum_step;
        logic div_step;
        logic load;
    } t_ctrl_cmd;

    typedef struct packed {
        logic due;
        logic gather_last;
        logic sum_last;
        logic div_last;
        logic out_free;
    } t_ctrl_sts;

endpackage

/* src/rmf_ctrl.sv */
module rmf_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  rmf_pkg::t_ctrl_sts i_sts,
    output rmf_pkg::t_ctrl_cmd o_cmd,
    output logic               o_in_stall
);

    rmf_pkg::t_state r_state;
    rmf_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rmf_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            rmf_pkg::ST_IDLE: begin
                if (i_in_valid && i_sts.due) begin
                    n_state = rmf_pkg::ST_GATHER;
                end
            end
            rmf_pkg::ST_GATHER: begin
                if (i_sts.gather_last) begin
                    n_state = rmf_pkg::ST_DRAIN;
                end
            end
            rmf_pkg::ST_DRAIN: begin
                n_state = rmf_pkg::ST_SUM;
            end
            rmf_pkg::ST_SUM: begin
                if (i_sts.sum_last) begin
                    n_state = rmf_pkg::ST_DIV;
                end
            end
            rmf_pkg::ST_DIV: begin
                if (i_sts.div_last) begin
                    n_state = rmf_pkg::ST_LOAD;
                end
            end
            rmf_pkg::ST_LOAD: begin
                if (i_sts.out_free) begin
                    n_state = rmf_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rmf_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd              = '0;
        o_in_stall         = 1'b1;
        case (r_state)
            rmf_pkg::ST_IDLE: begin
                o_in_stall         = 1'b0;
                o_cmd.accept       = i_in_valid;
                o_cmd.gather_start = i_in_valid && i_sts.due;
            end
            rmf_pkg::ST_GATHER: begin
                o_cmd.gather_step = 1'b1;
            end
            rmf_pkg::ST_SUM: begin
                o_cmd.sum_step = 1'b1;
            end
            rmf_pkg::ST_DIV: begin
                o_cmd.div_step = 1'b1;
            end
            rmf_pkg::ST_LOAD: begin
                o_cmd.load = i_sts.out_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

endmodule

/* src/rmf_datapath.sv */
module rmf_datapath #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_WINDOW = 9
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [rmf_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [rmf_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  rmf_pkg::t_in_item                 i_in_data,
    input  rmf_pkg::t_ctrl_cmd                i_cmd,
    output rmf_pkg::t_ctrl_sts                o_sts,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output rmf_pkg::t_out_item                o_out_data
);

    localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int RING  = MAX_WINDOW + 1;
    localparam int RGW   = $clog2(RING);
    localparam int NMAX  = MAX_WINDOW * MAX_WINDOW;
    localparam int NW    = $clog2(NMAX + 1);
    localparam int SW    = rmf_pkg::PIX_W + NW;
    localparam int DCW   = $clog2(SW);
    localparam int LW    = WW + 4;
    localparam int DW    = LW + 1;
    localparam int HW    = rmf_pkg::ROW_W;
    localparam int DEPTH = RING * (2 ** CW);
    localparam logic [3:0] SZ_CAP = 4'((MAX_WINDOW - 1) | 1);

    // Configuration registers.
    logic [3:0]  r_win_size;
    logic [5:0]  r_trim;
    logic [10:0] r_img_w;
    logic [12:0] r_img_h;

    // Frame position.
    logic [WW-1:0]  r_in_col, r_out_col;
    logic [HW-1:0]  r_in_row, r_out_row;
    logic [RGW-1:0] r_in_ring, r_out_ring;
    logic           r_in_done;
    logic [DW-1:0]  r_dist;

    // Window walk.
    logic signed [HW:0]   r_gy;
    logic signed [WW+1:0] r_gx;
    logic [RGW-1:0]       r_gring;
    logic [3:0]           r_gi, r_gj;
    logic                 r_rd_vld;
    logic [7:0]           r_rd_data;

    logic [7:0]    mem [DEPTH];
    logic [7:0]    r_sort [NMAX];
    logic [7:0]    n_sort [NMAX];
    logic [NMAX-1:0] ge;
    logic [NW-1:0] r_cnt;
    logic [NW-1:0] r_sidx;
    logic [SW-1:0] r_acc;
    logic [SW-1:0] r_quo;
    logic [NW-1:0] r_rem;
    logic [DCW-1:0] r_dcnt;

    logic               r_out_vld;
    rmf_pkg::t_out_item r_out;

    // Derived geometry.
    logic [3:0]      sz_odd, sz;
    logic [2:0]      rr;
    logic [WW-1:0]   w, wm1;
    logic [HW-1:0]   h, hm1;
    logic [7:0]      n_full;
    logic [NW-1:0]   n, mid, k, lo, hi, dv;
    logic [WW+2:0]   rw_prod;
    logic [WW-1:0]   minr;
    logic [LW-1:0]   lag;
    logic            count;
    logic signed [WW+1:0] gx0;
    logic signed [HW:0]   gy0;
    logic [RGW:0]    ring_wrap;
    logic [RGW-1:0]  ring0;
    logic [WW-1:0]   gcol;
    logic signed [HW:0] ngy;
    logic [SW-1:0]   n_acc;
    logic [NW:0]     dtrial;
    logic            dge;
    logic            taken;
    logic            row_last;
    logic            frame_last;

    always_comb begin
        sz_odd = r_win_size[0] ? r_win_size : r_win_size + 4'd1;
        sz     = (sz_odd > SZ_CAP) ? SZ_CAP : sz_odd;
        rr     = sz[3:1];
        if (r_img_w == 11'd0) begin
            w = WW'(1);
        end else if (32'(r_img_w) > MAX_WIDTH) begin
            w = WW'(MAX_WIDTH);
        end else begin
            w = WW'(r_img_w);
        end
        if (r_img_h == 13'd0) begin
            h = HW'(1);
        end else if (32'(r_img_h) > rmf_pkg::MAX_HEIGHT) begin
            h = HW'(rmf_pkg::MAX_HEIGHT);
        end else begin
            h = r_img_h;
        end
        wm1    = w - WW'(1);
        hm1    = h - HW'(1);
        n_full = {4'd0, sz} * {4'd0, sz};
        n      = NW'(n_full);
        mid    = n >> 1;
        k      = (8'(r_trim) > 8'(mid)) ? mid : NW'(r_trim);
        lo     = mid - k;
        hi     = mid + k;
        dv     = NW'({k, 1'b1});
        rw_prod = (WW+3)'(rr) * (WW+3)'(w);
        minr   = (WW'(rr) < wm1) ? WW'(rr) : wm1;
        lag    = LW'(rw_prod) + LW'(minr);
    end

    // An item is counted unless it is a pad arriving before the frame is complete.
    assign count = !(i_in_data.pad_item && !r_in_done);

    // Window start and column clamp; edge rows and columns repeat outside the frame.
    always_comb begin
        gx0       = $signed({2'b00, r_out_col}) - $signed((WW+2)'(rr));
        gy0       = $signed({1'b0, r_out_row}) - $signed((HW+1)'(rr));
        ring_wrap = (RGW+1)'(r_out_ring) + (RGW+1)'(RING) - (RGW+1)'(rr);
        if (r_out_row < HW'(rr)) begin
            ring0 = '0;
        end else if (r_out_ring >= RGW'(rr)) begin
            ring0 = r_out_ring - RGW'(rr);
        end else begin
            ring0 = RGW'(ring_wrap);
        end
        if (r_gx < 0) begin
            gcol = '0;
        end else if (r_gx > $signed({2'b00, wm1})) begin
            gcol = wm1;
        end else begin
            gcol = WW'(r_gx);
        end
        ngy = r_gy + $signed((HW+1)'(1));
    end

    // Sorted insertion network, which also shifts down during summing.
    always_comb begin
        for (int p = 0; p < NMAX; p++) begin
            ge[p] = (NW'(p) < r_cnt) && (r_sort[p] <= r_rd_data);
        end
        for (int p = 0; p < NMAX; p++) begin
            n_sort[p] = r_sort[p];
        end
        if (i_cmd.sum_step) begin
            for (int p = 0; p < NMAX - 1; p++) begin
                n_sort[p] = r_sort[p + 1];
            end
        end else if (r_rd_vld) begin
            if (!ge[0]) begin
                n_sort[0] = r_rd_data;
            end
            for (int p = 1; p < NMAX; p++) begin
                if (!ge[p]) begin
                    n_sort[p] = ge[p - 1] ? r_rd_data : r_sort[p - 1];
                end
            end
        end
    end

    always_comb begin
        n_acc  = r_acc + ((r_sidx >= lo) ? SW'(r_sort[0]) : SW'(0));
        dtrial = {r_rem, r_quo[SW-1]};
        dge    = dtrial >= {1'b0, dv};
    end

    assign taken      = r_out_vld && !i_out_stall;
    assign row_last   = (r_out_col + WW'(1) >= w);
    assign frame_last = row_last && (r_out_row + HW'(1) >= h);

    always_comb begin
        o_sts.due         = count && (r_dist >= DW'(lag));
        o_sts.gather_last = (r_gi == sz - 4'd1) && (r_gj == sz - 4'd1);
        o_sts.sum_last    = (r_sidx == hi);
        o_sts.div_last    = (r_dcnt == DCW'(SW - 1));
        o_sts.out_free    = !r_out_vld || taken;
    end

    // Line store: written on accepted pixels, read during the window walk.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && !r_in_done && !i_in_data.pad_item) begin
            mem[{r_in_ring, r_in_col[CW-1:0]}] <= i_in_data.pixel_in;
        end
        if (i_cmd.gather_step) begin
            r_rd_data <= mem[{r_gring, gcol[CW-1:0]}];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int p = 0; p < NMAX; p++) begin
            r_sort[p] <= n_sort[p];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_size <= 4'd3;
            r_trim     <= 6'd0;
            r_img_w    <= 11'd640;
            r_img_h    <= 13'd480;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                rmf_pkg::CFG_WINDOW_SIZE:  r_win_size <= i_cfg_data[3:0];
                rmf_pkg::CFG_TRIM_K:       r_trim     <= i_cfg_data[5:0];
                rmf_pkg::CFG_IMAGE_WIDTH:  r_img_w    <= i_cfg_data[10:0];
                rmf_pkg::CFG_IMAGE_HEIGHT: r_img_h    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col   <= '0;
            r_in_row   <= '0;
            r_in_ring  <= '0;
            r_in_done  <= 1'b0;
            r_dist     <= '0;
            r_out_col  <= '0;
            r_out_row  <= '0;
            r_out_ring <= '0;
            r_rd_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.gather_step;
            if (i_cmd.accept) begin
                if (count) begin
                    r_dist <= r_dist + DW'(1);
                end
                if (!r_in_done && !i_in_data.pad_item) begin
                    if (r_in_col + WW'(1) >= w) begin
                        r_in_col  <= '0;
                        r_in_row  <= r_in_row + HW'(1);
                        r_in_ring <= (r_in_ring == RGW'(RING - 1)) ? '0 : r_in_ring + RGW'(1);
                        if (r_in_row + HW'(1) >= h) begin
                            r_in_done <= 1'b1;
                        end
                    end else begin
                        r_in_col <= r_in_col + WW'(1);
                    end
                end
            end
            if (i_cmd.load) begin
                r_out_vld       <= 1'b1;
                r_out.pixel_out <= r_quo[7:0];
                r_out.frame_end <= frame_last;
                if (frame_last) begin
                    // Last pixel of the frame: every position returns to the start.
                    r_in_col   <= '0;
                    r_in_row   <= '0;
                    r_in_ring  <= '0;
                    r_in_done  <= 1'b0;
                    r_dist     <= '0;
                    r_out_col  <= '0;
                    r_out_row  <= '0;
                    r_out_ring <= '0;
                end else begin
                    r_dist <= r_dist - DW'(1);
                    if (row_last) begin
                        r_out_col  <= '0;
                        r_out_row  <= r_out_row + HW'(1);
                        r_out_ring <= (r_out_ring == RGW'(RING - 1)) ? '0 : r_out_ring + RGW'(1);
                    end else begin
                        r_out_col <= r_out_col + WW'(1);
                    end
                end
            end else if (taken) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Window walk, ranking sum and restoring divider.
    always_ff @(posedge i_clk) begin
        if (i_cmd.gather_start) begin
            r_gx    <= gx0;
            r_gy    <= gy0;
            r_gring <= ring0;
            r_gi    <= '0;
            r_gj    <= '0;
            r_cnt   <= '0;
            r_sidx  <= '0;
            r_acc   <= '0;
        end else begin
            if (i_cmd.gather_step) begin
                if (r_gi == sz - 4'd1) begin
                    r_gi <= '0;
                    r_gj <= r_gj + 4'd1;
                    r_gx <= gx0;
                    r_gy <= ngy;
                    if (ngy > 0 && ngy <= $signed({1'b0, hm1})) begin
                        r_gring <= (r_gring == RGW'(RING - 1)) ? '0 : r_gring + RGW'(1);
                    end
                end else begin
                    r_gi <= r_gi + 4'd1;
                    r_gx <= r_gx + $signed((WW+2)'(1));
                end
            end
            if (r_rd_vld) begin
                r_cnt <= r_cnt + NW'(1);
            end
            if (i_cmd.sum_step) begin
                r_acc  <= n_acc;
                r_sidx <= r_sidx + NW'(1);
                if (o_sts.sum_last) begin
                    r_quo  <= n_acc;
                    r_rem  <= '0;
                    r_dcnt <= '0;
                end
            end
            if (i_cmd.div_step) begin
                r_rem  <= dge ? NW'(dtrial - {1'b0, dv}) : NW'(dtrial);
                r_quo  <= {r_quo[SW-2:0], dge};
                r_dcnt <= r_dcnt + DCW'(1);
            end
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

/* src/raster_median_filter.sv */
// Streaming two-dimensional median / trimmed-mean filter for one 8-bit pixel channel.
// Input channel: i_in_valid / o_in_stall carry one transaction per pixel in raster
// order; a transaction with pad_item set carries no pixel and, once the frame's last
// pixel has been taken, pushes out the rows that are still pending.
// Output channel: o_out_valid / i_out_stall return filtered pixels in raster order,
// with frame_end set on the last pixel of each frame.
// Configuration must be written through i_cfg_we / i_cfg_index / i_cfg_data only
// while idle; the block does not enforce this. Output n of a frame is produced by
// the transaction numbered n + r*W + min(r, W-1), where r is half the window side
// and W the image width; pads offered before the frame's last pixel are not counted.
// A transaction that yields no result is taken without holding the input off. One that
// yields a result holds the input off while the single line store read port walks the
// window, the serial ranking sum runs and the bit-serial divider forms the trimmed mean
// for a window side S and trim k (saturated at (S*S)/2), and then until the output
// register is free; the result is placed there and the next transaction can be taken
// in the cycle after.
// Reset (synchronous, active low) restores the default configuration, clears
// all frame positions and empties the output register; line store contents are kept.
// A stalled result stays in the output register, and the block keeps taking
// transactions until it has a new result of its own to place there.
module raster_median_filter #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_WINDOW = 9
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rmf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rmf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  rmf_pkg::t_in_item              i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output rmf_pkg::t_out_item             o_out_data
);

    // Command and status between the sequencer and the datapath.
    rmf_pkg::t_ctrl_cmd cmd;
    rmf_pkg::t_ctrl_sts sts;

    // The sequencer accepts a transaction only in its idle state, and walks the
    // window, the ranking sum and the division for transactions that produce a result.
    rmf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // The datapath holds the line store, the sorted window, the arithmetic and
    // the output register that separates the two channels.
    rmf_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_WINDOW (MAX_WINDOW)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

/* src/rmf_checker.sv */
`include "raster_median_filter_defines.svh"

module rmf_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input rmf_pkg::t_out_item o_out_data
);

    // A waiting result holds until it is taken.
    `RMF_CHECK(a_out_hold, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))

    // A new result is only placed while input is held off.
    `RMF_CHECK(a_out_rise, $rose(o_out_valid) |-> $past(o_in_stall))

    // Input is only held off after a transaction has been offered.
    `RMF_CHECK(a_stall_rise, $rose(o_in_stall) |-> $past(i_in_valid))

endmodule

bind raster_median_filter rmf_checker u_rmf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
